// ----- sv/skc_pkg.sv -----
// Shared widths, constants and register indexes for the soft-knee compressor curve.
package skc_pkg;

	// Field widths
	localparam int LVL_W   = 16;
	localparam int THR_W   = 16;
	localparam int RATIO_W = 13;
	localparam int KNEE_W  = 14;

	// Ratio is fixed point with this many fraction bits, so 1.0 is 1 << FRAC_BITS
	localparam int FRAC_BITS = 8;
	localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_BITS;

	// Datapath widths
	localparam int EXT_W  = 18;                 // signed level math with knee offsets
	localparam int A_W    = 16;                 // knee offset d or overshoot in - thresh
	localparam int P_W    = 30;                 // d*d (or overshoot) before the ratio term
	localparam int KR_W   = KNEE_W + RATIO_W;   // knee * ratio
	localparam int DEN_W  = KR_W + 2;           // 4 * knee * ratio
	localparam int NUM_W  = 44;                 // rounded numerator
	localparam int QUO_W  = 17;                 // quotient bits, one divider stage each
	localparam int RES_W  = 19;                 // level minus reduction before saturation

	// Configuration port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_RATIO     = 2'd1,
		REG_KNEE      = 2'd2
	} reg_idx_t;

endpackage

// ----- sv/skc_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a level carried alongside.
module skc_divider (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic [skc_pkg::NUM_W-1:0]          num,
	input  logic [skc_pkg::DEN_W-1:0]          den,
	input  logic signed [skc_pkg::LVL_W-1:0]   lin,
	output logic                               out_valid,
	output logic [skc_pkg::QUO_W-1:0]          quot,
	output logic signed [skc_pkg::LVL_W-1:0]   lin_out
);
	import skc_pkg::*;

	// Per-stage registers; index k holds the item after k quotient bits
	logic                      v_s   [1:QUO_W];
	logic [NUM_W-1:0]          rem_s [1:QUO_W];
	logic [DEN_W-1:0]          den_s [1:QUO_W];
	logic [QUO_W-1:0]          quo_s [1:QUO_W];
	logic signed [LVL_W-1:0]   lin_s [1:QUO_W];

	genvar i;
	for (i = 0; i < QUO_W; i++) begin : g_bit
		localparam int B = QUO_W - 1 - i;

		logic                    v_in;
		logic [NUM_W-1:0]        rem_in;
		logic [DEN_W-1:0]        den_in;
		logic [QUO_W-1:0]        quo_in;
		logic signed [LVL_W-1:0] lin_in;
		logic [NUM_W:0]          dsh;
		logic                    ge;

		// Stage input: divider port for the first bit, previous stage otherwise
		if (i == 0) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
			assign lin_in = lin;
		end else begin : g_next
			assign v_in   = v_s[i];
			assign rem_in = rem_s[i];
			assign den_in = den_s[i];
			assign quo_in = quo_s[i];
			assign lin_in = lin_s[i];
		end

		// Trial subtract of the shifted divisor
		assign dsh = {{(NUM_W + 1 - DEN_W){1'b0}}, den_in} << B;
		assign ge  = {1'b0, rem_in} >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? (rem_in - dsh[NUM_W-1:0]) : rem_in;
				den_s[i+1] <= den_in;
				quo_s[i+1] <= quo_in | (QUO_W'(ge) << B);
				lin_s[i+1] <= lin_in;
			end
		end
	end

	assign out_valid = v_s[QUO_W];
	assign quot      = quo_s[QUO_W];
	assign lin_out   = lin_s[QUO_W];

endmodule

// ----- sv/soft_knee_compressor_curve.sv -----
// Soft-knee compressor static curve: Q7.8 dB level in, compressed level out, saturated.
// Throughput: one item per cycle while the skid register is empty;
// the 17-stage divider (one quotient bit each) sets the depth.
// A stalled result parks in a one-item skid register; input stalls only while it is full.
// Reset clears all valid bits and loads threshold 0, ratio 1.0 and a hard knee.
module soft_knee_compressor_curve (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [skc_pkg::ADDR_W-1:0]          paddr,
	input  logic [skc_pkg::DATA_W-1:0]          pwdata,
	output logic [skc_pkg::DATA_W-1:0]          prdata,
	output logic                                pready,
	// input channel
	input  logic                                level_in_valid,
	output logic                                level_in_stall,
	input  logic signed [skc_pkg::LVL_W-1:0]    level_in,
	// output channel
	output logic                                level_out_valid,
	input  logic                                level_out_stall,
	output logic signed [skc_pkg::LVL_W-1:0]    level_out
);
	import skc_pkg::*;

	// Configuration registers
	logic signed [THR_W-1:0] thr_q;
	logic [RATIO_W-1:0]      ratio_q;
	logic [KNEE_W-1:0]       knee_q;
	reg_idx_t                idx;
	logic                    wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= '0;
			ratio_q <= RATIO_ONE;
			knee_q  <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_THRESHOLD: thr_q   <= pwdata[THR_W-1:0];
				REG_RATIO:     ratio_q <= pwdata[RATIO_W-1:0];
				REG_KNEE:      knee_q  <= pwdata[KNEE_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (idx)
			REG_THRESHOLD: prdata = {{(DATA_W - THR_W){thr_q[THR_W-1]}}, thr_q};
			REG_RATIO:     prdata = {{(DATA_W - RATIO_W){1'b0}}, ratio_q};
			REG_KNEE:      prdata = {{(DATA_W - KNEE_W){1'b0}}, knee_q};
			default:       prdata = '0;
		endcase
	end

	// Ratio below 1.0 acts as 1.0
	logic [RATIO_W-1:0] r_eff;
	logic [RATIO_W-1:0] r_m1;
	assign r_eff = (ratio_q < RATIO_ONE) ? RATIO_ONE : ratio_q;
	assign r_m1  = r_eff - RATIO_ONE;

	// Pipeline advance: stops only while the skid register holds an item
	logic skid_v_q;
	logic en;
	assign en             = !skid_v_q;
	assign level_in_stall = skid_v_q;

	// Stage 1: region decision and offset into the curve
	logic signed [EXT_W-1:0] lin_x, thr_x, knee_x, lo_x, hi_x;
	logic                    pass, in_knee;
	logic [A_W-1:0]          a_d;

	assign lin_x  = {{(EXT_W - LVL_W){level_in[LVL_W-1]}}, level_in};
	assign thr_x  = {{(EXT_W - THR_W){thr_q[THR_W-1]}}, thr_q};
	assign knee_x = {{(EXT_W - KNEE_W){1'b0}}, knee_q};
	assign lo_x   = thr_x - knee_x;
	assign hi_x   = thr_x + knee_x;

	always_comb begin
		logic signed [EXT_W-1:0] diff;
		pass    = lin_x <= lo_x;
		in_knee = !pass && (lin_x < hi_x);
		diff    = in_knee ? (lin_x - lo_x) : (lin_x - thr_x);
		a_d     = pass ? '0 : diff[A_W-1:0];
	end

	logic                    v_s1, knee_s1;
	logic [A_W-1:0]          a_s1;
	logic signed [LVL_W-1:0] lin_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= level_in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			knee_s1 <= in_knee;
			a_s1    <= a_d;
			lin_s1  <= level_in;
		end
	end

	// Stage 2: square of the knee offset (overshoot above the knee passes through), divisor select
	logic [A_W-1:0]       mul_b;
	logic [2*A_W-1:0]     sq;
	logic [KR_W-1:0]      kr;
	logic [DEN_W-1:0]     den_d;

	assign mul_b = knee_s1 ? a_s1 : A_W'(1);
	assign sq    = a_s1 * mul_b;
	assign kr    = knee_q * r_eff;
	assign den_d = knee_s1 ? {kr, 2'b00} : {{(DEN_W - RATIO_W){1'b0}}, r_eff};

	logic                    v_s2;
	logic [P_W-1:0]          p_s2;
	logic [DEN_W-1:0]        den_s2;
	logic signed [LVL_W-1:0] lin_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2   <= sq[P_W-1:0];
			den_s2 <= den_d;
			lin_s2 <= lin_s1;
		end
	end

	// Stage 3: times (ratio - 1)
	logic [P_W+RATIO_W-1:0] num_d;
	assign num_d = p_s2 * r_m1;

	logic                    v_s3;
	logic [P_W+RATIO_W-1:0]  num_s3;
	logic [DEN_W-1:0]        den_s3;
	logic signed [LVL_W-1:0] lin_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= num_d;
			den_s3 <= den_s2;
			lin_s3 <= lin_s2;
		end
	end

	// Stage 4: add half the divisor for round-half-up
	logic                    v_s4;
	logic [NUM_W-1:0]        num_s4;
	logic [DEN_W-1:0]        den_s4;
	logic signed [LVL_W-1:0] lin_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4 <= NUM_W'(num_s3) + NUM_W'(den_s3 >> 1);
			den_s4 <= den_s3;
			lin_s4 <= lin_s3;
		end
	end

	// Stages 5 to 21: quotient, one bit per stage
	logic                    dv_valid;
	logic [QUO_W-1:0]        dv_quot;
	logic signed [LVL_W-1:0] dv_lin;

	skc_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.num       (num_s4),
		.den       (den_s4),
		.lin       (lin_s4),
		.out_valid (dv_valid),
		.quot      (dv_quot),
		.lin_out   (dv_lin)
	);

	// Subtract the reduction and saturate to the level range
	logic signed [RES_W-1:0] res;
	logic signed [LVL_W-1:0] res_sat;

	assign res = {{(RES_W - LVL_W){dv_lin[LVL_W-1]}}, dv_lin}
		- {{(RES_W - QUO_W){1'b0}}, dv_quot};

	always_comb begin
		if (res[RES_W-1] && !(&res[RES_W-2:LVL_W-1])) begin
			res_sat = {1'b1, {(LVL_W - 1){1'b0}}};
		end else if (!res[RES_W-1] && (|res[RES_W-2:LVL_W-1])) begin
			res_sat = {1'b0, {(LVL_W - 1){1'b1}}};
		end else begin
			res_sat = res[LVL_W-1:0];
		end
	end

	// Output register with one skid entry behind it
	logic                    out_v_q;
	logic signed [LVL_W-1:0] out_d_q;
	logic signed [LVL_W-1:0] skid_d_q;
	logic                    out_free, push;

	assign out_free = !out_v_q || !level_out_stall;
	assign push     = en && dv_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_d_q <= skid_v_q ? skid_d_q : res_sat;
		end else if (push) begin
			skid_d_q <= res_sat;
		end
	end

	assign level_out_valid = out_v_q;
	assign level_out       = out_d_q;

endmodule
